// ----- sv/isort_pkg.sv -----
// isort_pkg: shared types for the insertion sort engine.
// Used by isort_cell and insertion_sort_engine; depends on nothing else.
`default_nettype none

package isort_pkg;

  localparam int unsigned DataWidth = 32;

  typedef logic signed [DataWidth-1:0] data_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic  insert;   // place value into the sorted chain
    logic  shift;    // move every entry one cell toward the head
    data_t value;    // value being inserted
  } cell_ctrl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic  valid;    // cell holds an entry
    logic  gt;       // held entry is strictly greater than the broadcast value
    data_t data;     // held entry
  } cell_link_t;

endpackage

`default_nettype wire

// ----- sv/insertion_sort_engine.sv -----
// Systolic insertion sort engine: top level with the chain of cells and drain control.
// Depends on isort_pkg and isort_cell.
// Each accepted input beat is inserted in a single step: every cell compares its entry
// with the new value at once and entries greater than it step one cell toward the
// tail, so equal values keep arrival order. Beats arriving while all CAPACITY cells
// are full are dropped and mark the set as overflowed. The beat marked final_item
// starts the drain: the chain shifts toward the head one cell per accepted output
// beat, giving one result per held entry in ascending order, end_of_run on the
// greatest, then drain mode and overflow clear for the next set. Input takes one beat
// per cycle while not draining; in_stall is high throughout the drain.
`default_nettype none

module insertion_sort_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  isort_pkg::data_t      value,
  input  logic                  final_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output isort_pkg::data_t      sorted_value,
  output logic                  end_of_run,
  output logic                  overflowed
);
  import isort_pkg::*;

  logic       draining;
  logic       draining_next;
  logic       dropped;
  logic       dropped_next;
  logic       in_fire;
  logic       out_fire;
  logic       full;
  cell_ctrl_t ctrl;
  cell_link_t links [CAPACITY];
  cell_link_t left_links [CAPACITY];
  cell_link_t right_links [CAPACITY];

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign full     = links[CAPACITY-1].valid;

  // Broadcast command to the chain
  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = out_fire;
  assign ctrl.value  = value;

  // Build the chain with fixed ends: head accepts first, tail feeds empties
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_links[i] = '{valid: 1'b1, gt: 1'b0, data: '0};
    end else begin : g_left
      assign left_links[i] = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_links[i] = '{valid: 1'b0, gt: 1'b0, data: '0};
    end else begin : g_right
      assign right_links[i] = links[i+1];
    end

    isort_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_link  (left_links[i]),
      .right_link (right_links[i]),
      .link       (links[i])
    );
  end

  // Advance drain mode and overflow flag
  always_comb begin
    draining_next = draining;
    dropped_next  = dropped;
    if (in_fire) begin
      dropped_next = dropped || full;
      if (final_item) begin
        draining_next = 1'b1;
      end
    end
    if (out_fire && end_of_run) begin
      draining_next = 1'b0;
      dropped_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      draining <= draining_next;
      dropped  <= dropped_next;
    end
  end

  // Present the head cell as the output beat
  assign in_stall     = draining;
  assign out_valid    = draining && links[0].valid;
  assign sorted_value = links[0].data;
  assign end_of_run   = !links[1].valid;
  assign overflowed   = dropped;

endmodule

`default_nettype wire

// ----- sv/isort_cell.sv -----
// isort_cell: one slot of the systolic insertion chain.
// Depends on isort_pkg for the command and neighbor link types.
`default_nettype none

module isort_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  isort_pkg::cell_ctrl_t  ctrl,
  input  isort_pkg::cell_link_t  left_link,
  input  isort_pkg::cell_link_t  right_link,
  output isort_pkg::cell_link_t  link
);
  import isort_pkg::*;

  logic  valid;
  data_t data;
  logic  gt;
  logic  take;
  data_t take_data;

  // Compare the held entry against the broadcast value
  assign gt = valid && (data > ctrl.value);

  // Load on insert when this entry moves down or the open slot is next in line
  assign take      = gt || (!valid && left_link.valid);
  assign take_data = left_link.gt ? left_link.data : ctrl.value;

  // Hold, insert or shift toward the head
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_link.valid;
    end else if (ctrl.insert && take) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= right_link.data;
    end else if (ctrl.insert && take) begin
      data <= take_data;
    end
  end

  assign link.valid = valid;
  assign link.gt    = gt;
  assign link.data  = data;

endmodule

`default_nettype wire
